### src/vad_pkg.sv
// shared types, constants and codes of the windowed voice activity detector
package vad_pkg;

   localparam int VAD_WINDOW_LENGTH = 2048;
   localparam int SAMPLE_BITS       = 16;
   localparam int MAX_CHANNELS      = 2;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 17;

   // operation codes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_EVAL  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING       = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CROSS_THRESHOLD = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME_THRESH   = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOISE_FLOOR     = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERCENT_MIN     = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERCENT_MAX     = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCORE_REF       = 4'd7;

   // register reset values
   localparam logic [1:0]         RST_CHANNEL_COUNT   = 2'd1;
   localparam logic [16:0]        RST_SMOOTHING       = 17'd26214;
   localparam logic [16:0]        RST_CROSS_THRESHOLD = 17'd16384;
   localparam logic signed [15:0] RST_VOLUME_THRESH   = -16'sd10240;
   localparam logic signed [15:0] RST_NOISE_FLOOR     = -16'sd15360;
   localparam logic signed [15:0] RST_PERCENT_MIN     = -16'sd15360;
   localparam logic signed [15:0] RST_PERCENT_MAX     = 16'sd0;
   localparam logic [16:0]        RST_SCORE_REF       = 17'd16384;

   // fixed point constants
   localparam logic [16:0]        Q16_ONE      = 17'd65536;
   localparam logic [14:0]        PERCENT_FULL = 15'd25600;
   localparam logic signed [15:0] DB_FLOOR     = -16'sd25600;
   localparam logic [18:0]        DB_SCALE_Q16 = 19'd394566;
   localparam logic [19:0]        LOG_TOP      = 20'((SAMPLE_BITS - 1) * 65536);

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
   } req_type;

   typedef struct packed {
      logic [15:0]        rms_level;
      logic signed [15:0] rms_db;
      logic [15:0]        peak_level;
      logic signed [15:0] peak_db;
      logic [15:0]        smoothed_level;
      logic signed [15:0] smoothed_db;
      logic [15:0]        crossing_rate;
      logic [16:0]        voice_score;
      logic               voice_detected;
      logic [14:0]        volume_percent;
   } rsp_type;

endpackage

### src/vad_ram.sv
// generic simple dual port ram with registered read
module vad_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/vad_div.sv
// restoring divider, one quotient bit per cycle
module vad_div #(
   parameter int NUM_W = 42,
   parameter int DEN_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W:0]   rem_sh;
   logic             fits;
   logic [DEN_W:0]   rem_sub;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quo_in;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      rem_in  = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_in  = {quo_ff[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### src/vad_sqrt.sv
// integer square root, two radicand bits per cycle
module vad_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] radicand,
   output logic        done,
   output logic [15:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [31:0] v_ff;
   logic [31:0] res_ff;
   logic [31:0] bit_ff;
   logic [32:0] trial;
   logic        take;

   always_comb begin
      trial = {1'b0, res_ff} + {1'b0, bit_ff};
      take  = {1'b0, v_ff} >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff == 32'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= {1'b0, radicand};
         res_ff <= '0;
         bit_ff <= 32'h4000_0000;
      end else if (busy_ff) begin
         if (take) begin
            v_ff   <= v_ff - trial[31:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[15:0];

endmodule

### src/vad_log.sv
// level to decibels: log2 by repeated squaring, then scale to q8.8
module vad_log import vad_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        level,
   output logic               done,
   output logic signed [15:0] db
);

   typedef enum logic [1:0] {L_IDLE, L_SQUARE, L_SCALE, L_ROUND} log_state_type;

   log_state_type      state_ff;
   logic               done_ff;
   logic signed [15:0] db_ff;
   logic [4:0]         cnt_ff;
   logic [3:0]         e_ff;
   logic [15:0]        frac_ff;
   logic [31:0]        m_ff;
   logic [38:0]        prod_ff;

   logic [3:0]         e_in;
   logic [31:0]        m_start;
   logic [63:0]        sq;
   logic [31:0]        sq_sh;
   logic [19:0]        q;
   logic [19:0]        mag;
   logic [39:0]        rnd_sum;
   logic signed [16:0] db_neg;

   always_comb begin
      e_in = '0;
      for (int i = 0; i < 16; i++) begin
         if (level[i]) begin
            e_in = 4'(i);
         end
      end
      m_start = 32'(level) << (5'd30 - {1'b0, e_in});
      sq      = 64'(m_ff) * 64'(m_ff);
      sq_sh   = sq[61:30];
      q       = {e_ff, frac_ff};
      mag     = (q >= LOG_TOP) ? 20'd0 : (LOG_TOP - q);
      rnd_sum = {1'b0, prod_ff} + 40'h80_0000;
      db_neg  = -$signed({2'b00, rnd_sum[38:24]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            L_IDLE: begin
               if (start) begin
                  if (level == 16'd0) begin
                     db_ff   <= DB_FLOOR;
                     done_ff <= 1'b1;
                  end else begin
                     e_ff     <= e_in;
                     m_ff     <= m_start;
                     frac_ff  <= '0;
                     cnt_ff   <= 5'd16;
                     state_ff <= L_SQUARE;
                  end
               end
            end
            L_SQUARE: begin
               frac_ff <= {frac_ff[14:0], sq_sh[31]};
               m_ff    <= sq_sh[31] ? {1'b0, sq_sh[31:1]} : sq_sh;
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == 5'd1) begin
                  state_ff <= L_SCALE;
               end
            end
            L_SCALE: begin
               prod_ff  <= 39'(mag) * 39'(DB_SCALE_Q16);
               state_ff <= L_ROUND;
            end
            L_ROUND: begin
               db_ff    <= (db_neg < 17'(DB_FLOOR)) ? DB_FLOOR : db_neg[15:0];
               done_ff  <= 1'b1;
               state_ff <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign db   = db_ff;

endmodule

### src/windowed_voice_activity_detector_unit.sv
// top level of the windowed voice activity detector
//
//  channel  direction  payload    handshake
//  req      in         req_type   req_valid / req_ready
//  rsp      out        rsp_type   rsp_valid / rsp_ready
//  csr      in         index,data csr_valid / csr_ready (always ready)
//
//  push: PUSH_A, then PUSH_B once the window is full, then PUSH_W (ring read of the
//  oldest two samples through the single ram read port, then write back)
//  evaluate: paced by the ring scan (one read a cycle) and the shared serial divider
//  clear: done in the idle state; reset is synchronous, the ring needs no clearing pass
//  a finished result waits in the output register while pushes go on;
//  a later evaluate holds in its last step until that register is free
module windowed_voice_activity_detector_unit import vad_pkg::*; #(
   parameter int WINDOW_LENGTH = VAD_WINDOW_LENGTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int PTR_W = $clog2(WINDOW_LENGTH);
   localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);
   localparam int XW    = PTR_W + 1;
   localparam int SUM_W = 31 + PTR_W;
   localparam int DEN_W = (CNT_W > 17) ? CNT_W : 17;

   typedef enum logic [4:0] {
      IDLE, PUSH_A, PUSH_B, PUSH_W,
      EV_SCAN, EV_MEAN, EV_MEAN_W, EV_ROOT, EV_ROOT_W, EV_RATE, EV_RATE_W,
      EV_LOGR, EV_LOGR_W, EV_LOGP, EV_LOGP_W,
      EV_SM0, EV_SM1, EV_SM2, EV_SM3, EV_SM4,
      EV_SCORE, EV_SCORE_W, EV_PCT, EV_PCT_GO, EV_PCT_W, EV_OUT
   } state_type;

   // control state
   state_type          state_ff;
   logic [PTR_W-1:0]   wp_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]   cross_ff;
   logic [15:0]        sl_ff;
   logic signed [15:0] sdb_ff;
   logic               rsp_valid_ff;
   logic               scan_pend_ff;
   logic [CNT_W-1:0]   scan_left_ff;

   // configuration
   logic [1:0]         chan_ff;
   logic [16:0]        smooth_ff;
   logic [16:0]        cross_th_ff;
   logic signed [15:0] vol_th_ff;
   logic signed [15:0] noise_ff;
   logic signed [15:0] pmin_ff;
   logic signed [15:0] pmax_ff;
   logic [16:0]        ref_ff;

   // working registers
   logic signed [15:0] prev_ff;
   logic signed [15:0] mix_ff;
   logic signed [15:0] old_ff;
   logic               full_ff;
   logic               drop_ff;
   logic [30:0]        sq_new_ff;
   logic [30:0]        sq_old_ff;
   logic [PTR_W-1:0]   scan_addr_ff;
   logic [15:0]        peak_ff;
   logic [30:0]        mean_ff;
   logic [15:0]        rms_ff;
   logic [15:0]        rate_ff;
   logic signed [15:0] rdb_ff;
   logic signed [15:0] pdb_ff;
   logic signed [35:0] p0_ff;
   logic signed [35:0] p1_ff;
   logic signed [35:0] p2_ff;
   logic signed [35:0] p3_ff;
   logic [16:0]        score_ff;
   logic [14:0]        pct_ff;
   rsp_type            rsp_ff;

   // combinational
   logic               req_fire;
   logic               rsp_free;
   logic [16:0]        pair_sum;
   logic signed [15:0] mix_in;
   logic [PTR_W-1:0]   wp_next;
   logic [PTR_W-1:0]   scan_next;
   logic [PTR_W-1:0]   start_in;
   logic [PTR_W-1:0]   ram_rd_addr;
   logic [15:0]        ram_rd_data;
   logic [15:0]        ring_abs;
   logic [16:0]        f_clamp;
   logic [16:0]        g_weight;
   logic signed [17:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [35:0] mul_p;
   logic [33:0]        lvl_sum;
   logic signed [36:0] db_sum;
   logic [36:0]        db_mag;
   logic [36:0]        db_rnd;
   logic signed [17:0] pct_diff;
   logic [16:0]        pct_den;
   logic               voice;
   logic               div_start;
   logic [SUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   logic               div_done;
   logic [SUM_W-1:0]   div_quo;
   logic               sqrt_start;
   logic               sqrt_done;
   logic [15:0]        sqrt_root;
   logic               log_start;
   logic [15:0]        log_level;
   logic               log_done;
   logic signed [15:0] log_db;

   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // mono mix: floor of the pair average, or the left channel alone
   always_comb begin
      pair_sum = {req_data.left_sample[15], req_data.left_sample}
               + {req_data.right_sample[15], req_data.right_sample};
      if (MAX_CHANNELS >= 2 && chan_ff >= 2'd2) begin
         mix_in = pair_sum[16:1];
      end else begin
         mix_in = req_data.left_sample;
      end
   end

   // ring pointer arithmetic, wraps at any window length
   always_comb begin
      wp_next   = (wp_ff == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : wp_ff + 1'b1;
      scan_next = (scan_addr_ff == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : scan_addr_ff + 1'b1;
      if (fill_ff > CNT_W'(wp_ff)) begin
         start_in = PTR_W'(XW'(wp_ff) + XW'(WINDOW_LENGTH) - XW'(fill_ff));
      end else begin
         start_in = PTR_W'(XW'(wp_ff) - XW'(fill_ff));
      end
   end

   // ram read address: oldest sample on accept, its neighbor next, scan later
   always_comb begin
      unique case (state_ff)
         PUSH_A:  ram_rd_addr = wp_next;
         EV_SCAN: ram_rd_addr = scan_addr_ff;
         default: ram_rd_addr = wp_ff;
      endcase
   end

   assign ring_abs = ram_rd_data[15] ? (16'd0 - ram_rd_data) : ram_rd_data;

   // smoothing weights
   always_comb begin
      f_clamp  = (smooth_ff > Q16_ONE) ? Q16_ONE : smooth_ff;
      g_weight = Q16_ONE - f_clamp;
   end

   // one shared multiplier: squares on push, smoothing and percent on evaluate
   always_comb begin
      pct_diff = {{2{rdb_ff[15]}}, rdb_ff} - {{2{pmin_ff[15]}}, pmin_ff};
      unique case (state_ff)
         PUSH_A: begin
            mul_a = {{2{mix_ff[15]}}, mix_ff};
            mul_b = {{2{mix_ff[15]}}, mix_ff};
         end
         PUSH_B: begin
            mul_a = {{2{old_ff[15]}}, old_ff};
            mul_b = {{2{old_ff[15]}}, old_ff};
         end
         EV_SM0: begin
            mul_a = {2'b00, sl_ff};
            mul_b = {1'b0, g_weight};
         end
         EV_SM1: begin
            mul_a = {2'b00, rms_ff};
            mul_b = {1'b0, f_clamp};
         end
         EV_SM2: begin
            mul_a = {{2{sdb_ff[15]}}, sdb_ff};
            mul_b = {1'b0, g_weight};
         end
         EV_SM3: begin
            mul_a = {{2{rdb_ff[15]}}, rdb_ff};
            mul_b = {1'b0, f_clamp};
         end
         EV_PCT: begin
            mul_a = pct_diff;
            mul_b = {3'b000, PERCENT_FULL};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // smoothing combine, db rounds half away from zero
   always_comb begin
      lvl_sum = p0_ff[33:0] + p1_ff[33:0] + 34'd32768;
      db_sum  = 37'(p2_ff) + 37'(p3_ff);
      db_mag  = db_sum[36] ? (37'd0 - db_sum) : db_sum;
      db_rnd  = (db_mag + 37'd32768) >> 16;
   end

   assign pct_den = 17'({pmax_ff[15], pmax_ff} - {pmin_ff[15], pmin_ff});
   assign voice   = (rdb_ff >= noise_ff) && ({1'b0, rate_ff} < cross_th_ff)
                 && (rdb_ff > vol_th_ff);

   // unit starts and operand selection
   always_comb begin
      div_start  = 1'b0;
      div_num    = sum_ff;
      div_den    = DEN_W'(fill_ff);
      sqrt_start = (state_ff == EV_ROOT);
      log_start  = (state_ff == EV_LOGR) || (state_ff == EV_LOGP);
      log_level  = (state_ff == EV_LOGP) ? peak_ff : rms_ff;
      unique case (state_ff)
         EV_MEAN: begin
            div_start = (fill_ff != '0);
         end
         EV_RATE: begin
            div_start = (fill_ff >= CNT_W'(2));
            div_num   = SUM_W'({cross_ff, 16'h0000});
         end
         EV_SCORE: begin
            div_start = (ref_ff != '0);
            div_num   = SUM_W'({rate_ff, 16'h0000});
            div_den   = DEN_W'(ref_ff);
         end
         EV_PCT_GO: begin
            div_start = 1'b1;
            div_num   = SUM_W'(p0_ff[31:0]);
            div_den   = DEN_W'(pct_den);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   vad_ram #(
      .WIDTH(16),
      .DEPTH(WINDOW_LENGTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (state_ff == PUSH_W),
      .wr_addr(wp_ff),
      .wr_data(mix_ff),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   vad_div #(
      .NUM_W(SUM_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .numer   (div_num),
      .denom   (div_den),
      .done    (div_done),
      .quotient(div_quo)
   );

   vad_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .radicand(mean_ff),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   vad_log u_log (
      .clock(clock),
      .reset(reset),
      .start(log_start),
      .level(log_level),
      .done (log_done),
      .db   (log_db)
   );

   // configuration registers, index beyond the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff     <= RST_CHANNEL_COUNT;
         smooth_ff   <= RST_SMOOTHING;
         cross_th_ff <= RST_CROSS_THRESHOLD;
         vol_th_ff   <= RST_VOLUME_THRESH;
         noise_ff    <= RST_NOISE_FLOOR;
         pmin_ff     <= RST_PERCENT_MIN;
         pmax_ff     <= RST_PERCENT_MAX;
         ref_ff      <= RST_SCORE_REF;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT:   chan_ff     <= csr_data[1:0];
            CSR_SMOOTHING:       smooth_ff   <= csr_data;
            CSR_CROSS_THRESHOLD: cross_th_ff <= csr_data;
            CSR_VOLUME_THRESH:   vol_th_ff   <= csr_data[15:0];
            CSR_NOISE_FLOOR:     noise_ff    <= csr_data[15:0];
            CSR_PERCENT_MIN:     pmin_ff     <= csr_data[15:0];
            CSR_PERCENT_MAX:     pmax_ff     <= csr_data[15:0];
            CSR_SCORE_REF:       ref_ff      <= csr_data;
            default:             ;
         endcase
      end
   end

   // sequencer: window state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         cross_ff     <= '0;
         sl_ff        <= '0;
         sdb_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         scan_pend_ff <= 1'b0;
         scan_left_ff <= '0;
      end else begin
         // result register: loaded by the output step, freed by the receiver
         if (state_ff == EV_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_fire) begin
                  unique case (req_data.op)
                     OP_PUSH: begin
                        mix_ff   <= mix_in;
                        full_ff  <= (fill_ff == CNT_W'(WINDOW_LENGTH));
                        state_ff <= PUSH_A;
                     end
                     OP_EVAL: begin
                        scan_addr_ff <= start_in;
                        scan_left_ff <= fill_ff;
                        scan_pend_ff <= 1'b0;
                        peak_ff      <= '0;
                        state_ff     <= EV_SCAN;
                     end
                     OP_CLEAR: begin
                        wp_ff    <= '0;
                        fill_ff  <= '0;
                        sum_ff   <= '0;
                        cross_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            // oldest sample arrives, square the new one
            PUSH_A: begin
               sq_new_ff <= mul_p[30:0];
               old_ff    <= ram_rd_data;
               state_ff  <= full_ff ? PUSH_B : PUSH_W;
            end
            // neighbor of the oldest arrives, square the oldest
            PUSH_B: begin
               sq_old_ff <= mul_p[30:0];
               drop_ff   <= old_ff[15] != ram_rd_data[15];
               state_ff  <= PUSH_W;
            end
            PUSH_W: begin
               sum_ff   <= sum_ff - (full_ff ? SUM_W'(sq_old_ff) : '0) + SUM_W'(sq_new_ff);
               cross_ff <= cross_ff - CNT_W'(full_ff && drop_ff)
                         + CNT_W'((fill_ff != '0) && (prev_ff[15] != mix_ff[15]));
               fill_ff  <= full_ff ? fill_ff : fill_ff + 1'b1;
               wp_ff    <= wp_next;
               prev_ff  <= mix_ff;
               state_ff <= IDLE;
            end
            // peak over the window, one ring read per cycle
            EV_SCAN: begin
               if (scan_left_ff != '0) begin
                  scan_addr_ff <= scan_next;
                  scan_left_ff <= scan_left_ff - 1'b1;
                  scan_pend_ff <= 1'b1;
               end else begin
                  scan_pend_ff <= 1'b0;
               end
               if (scan_pend_ff && ring_abs > peak_ff) begin
                  peak_ff <= ring_abs;
               end
               if (scan_left_ff == '0 && !scan_pend_ff) begin
                  state_ff <= EV_MEAN;
               end
            end
            EV_MEAN: begin
               if (fill_ff == '0) begin
                  mean_ff  <= '0;
                  state_ff <= EV_ROOT;
               end else begin
                  state_ff <= EV_MEAN_W;
               end
            end
            EV_MEAN_W: begin
               if (div_done) begin
                  mean_ff  <= div_quo[30:0];
                  state_ff <= EV_ROOT;
               end
            end
            EV_ROOT: state_ff <= EV_ROOT_W;
            EV_ROOT_W: begin
               if (sqrt_done) begin
                  rms_ff   <= sqrt_root;
                  state_ff <= EV_RATE;
               end
            end
            EV_RATE: begin
               if (fill_ff < CNT_W'(2)) begin
                  rate_ff  <= '0;
                  state_ff <= EV_LOGR;
               end else begin
                  state_ff <= EV_RATE_W;
               end
            end
            EV_RATE_W: begin
               if (div_done) begin
                  rate_ff  <= div_quo[15:0];
                  state_ff <= EV_LOGR;
               end
            end
            EV_LOGR: state_ff <= EV_LOGR_W;
            EV_LOGR_W: begin
               if (log_done) begin
                  rdb_ff   <= log_db;
                  state_ff <= EV_LOGP;
               end
            end
            EV_LOGP: state_ff <= EV_LOGP_W;
            EV_LOGP_W: begin
               if (log_done) begin
                  pdb_ff   <= log_db;
                  state_ff <= EV_SM0;
               end
            end
            EV_SM0: begin
               p0_ff    <= mul_p;
               state_ff <= EV_SM1;
            end
            EV_SM1: begin
               p1_ff    <= mul_p;
               state_ff <= EV_SM2;
            end
            EV_SM2: begin
               p2_ff    <= mul_p;
               state_ff <= EV_SM3;
            end
            EV_SM3: begin
               p3_ff    <= mul_p;
               state_ff <= EV_SM4;
            end
            EV_SM4: begin
               sl_ff    <= lvl_sum[31:16];
               sdb_ff   <= db_sum[36] ? (16'd0 - db_rnd[15:0]) : db_rnd[15:0];
               state_ff <= EV_SCORE;
            end
            EV_SCORE: begin
               if (ref_ff == '0) begin
                  score_ff <= '0;
                  state_ff <= EV_PCT;
               end else begin
                  state_ff <= EV_SCORE_W;
               end
            end
            EV_SCORE_W: begin
               if (div_done) begin
                  score_ff <= (div_quo >= SUM_W'(Q16_ONE)) ? 17'd0
                            : (Q16_ONE - div_quo[16:0]);
                  state_ff <= EV_PCT;
               end
            end
            // empty range or at or below min gives zero, at or above max full
            EV_PCT: begin
               if (pmax_ff <= pmin_ff || rdb_ff <= pmin_ff) begin
                  pct_ff   <= '0;
                  state_ff <= EV_OUT;
               end else if (rdb_ff >= pmax_ff) begin
                  pct_ff   <= PERCENT_FULL;
                  state_ff <= EV_OUT;
               end else begin
                  p0_ff    <= mul_p;
                  state_ff <= EV_PCT_GO;
               end
            end
            EV_PCT_GO: state_ff <= EV_PCT_W;
            EV_PCT_W: begin
               if (div_done) begin
                  pct_ff   <= div_quo[14:0];
                  state_ff <= EV_OUT;
               end
            end
            EV_OUT: begin
               if (rsp_free) begin
                  rsp_ff.rms_level      <= rms_ff;
                  rsp_ff.rms_db         <= rdb_ff;
                  rsp_ff.peak_level     <= peak_ff;
                  rsp_ff.peak_db        <= pdb_ff;
                  rsp_ff.smoothed_level <= sl_ff;
                  rsp_ff.smoothed_db    <= sdb_ff;
                  rsp_ff.crossing_rate  <= rate_ff;
                  rsp_ff.voice_score    <= score_ff;
                  rsp_ff.voice_detected <= voice;
                  rsp_ff.volume_percent <= pct_ff;
                  state_ff              <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // window bookkeeping checks
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW_LENGTH))
      else $error("fill count beyond window length");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff < CNT_W'(WINDOW_LENGTH)) |-> (fill_ff == CNT_W'(wp_ff)))
      else $error("write pointer and fill count disagree before wrap");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (cross_ff == '0 && sum_ff == '0))
      else $error("empty window holds energy or crossings");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == EV_OUT))
      else $error("response raised outside the output step");

endmodule

### verif/tb_windowed_voice_activity_detector_unit.sv
// self-checking testbench of the windowed voice activity detector unit
`timescale 1ns / 100ps

module tb_windowed_voice_activity_detector_unit;
   import vad_pkg::*;

   localparam int RING_DEPTH  = VAD_WINDOW_LENGTH;
   localparam int CYCLE_LIMIT = 25000000;
   // settling margin that covers any push still in flight after the queues drain
   localparam int SETTLE_CYCLES = 64;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   windowed_voice_activity_detector_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // pending stimulus and expected evaluate results
   req_type pending_frames[$];
   rsp_type expected_reports[$];
   int      sent_count;
   int      taken_count;
   int      error_count;

   // shadow copy of the block state
   logic signed [15:0] shadow_ring [RING_DEPTH];
   int unsigned        shadow_wptr;
   int unsigned        shadow_fill;
   longint unsigned    shadow_square_sum;
   int unsigned        shadow_crossings;
   int unsigned        shadow_smooth_level;
   int                 shadow_smooth_db;

   // shadow copy of the registers
   logic [1:0]         cfg_channels;
   logic [16:0]        cfg_smoothing;
   logic [16:0]        cfg_cross_thr;
   logic signed [15:0] cfg_volume_thr;
   logic signed [15:0] cfg_noise_floor;
   logic signed [15:0] cfg_pct_min;
   logic signed [15:0] cfg_pct_max;
   logic [16:0]        cfg_score_ref;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // append to the tail of the queues
   task automatic queue_frame(req_type fr);
      pending_frames.insert(pending_frames.size(), fr);
   endtask

   task automatic queue_report(rsp_type rep);
      expected_reports.insert(expected_reports.size(), rep);
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // 20*log10(level / full scale) in Q8.8 through a fixed point log2
   function automatic int level_to_db(int unsigned lvl);
      int unsigned     e;
      int unsigned     frac;
      longint unsigned m;
      longint unsigned q;
      longint unsigned top;
      longint unsigned mag;
      longint          db;
      if (lvl == 0) return int'(DB_FLOOR);
      e    = 0;
      frac = 0;
      while (e < 31 && (lvl >> (e + 1)) != 0) e++;
      if (e <= 30) m = longint'(lvl) << (30 - e);
      else m = longint'(lvl) >> (e - 30);
      for (int i = 0; i < 16; i++) begin
         m    = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac = frac | 1;
            m    = m >> 1;
         end
      end
      q   = (longint'(e) << 16) + frac;
      top = longint'(SAMPLE_BITS - 1) << 16;
      mag = (q >= top) ? 64'd0 : top - q;
      db  = -longint'((mag * longint'(DB_SCALE_Q16) + (64'd1 << 23)) >> 24);
      if (db < longint'(DB_FLOOR)) db = longint'(DB_FLOOR);
      return int'(db);
   endfunction

   function automatic longint round_half_away(longint t);
      longint unsigned u;
      if (t < 0) begin
         u = longint'(-t);
         return -longint'((u + 32768) >> 16);
      end
      u = t;
      return longint'((u + 32768) >> 16);
   endfunction

   function automatic bit crosses(int a, int b);
      return (a < 0) != (b < 0);
   endfunction

   task automatic store_sample(int s);
      int unsigned wp;
      int          prev;
      int          old;
      wp   = shadow_wptr % RING_DEPTH;
      prev = 0;
      if (shadow_fill > 0) prev = shadow_ring[(wp + RING_DEPTH - 1) % RING_DEPTH];
      // full window: the oldest sample and its crossing drop out
      if (shadow_fill >= RING_DEPTH) begin
         old = shadow_ring[wp];
         shadow_square_sum = shadow_square_sum - longint'(old * old);
         shadow_crossings  = shadow_crossings
                           - crosses(old, shadow_ring[(wp + 1) % RING_DEPTH]);
         shadow_fill = RING_DEPTH - 1;
      end
      if (shadow_fill > 0) shadow_crossings = shadow_crossings + crosses(prev, s);
      shadow_ring[wp]   = 16'(s);
      shadow_square_sum = shadow_square_sum + longint'(s * s);
      shadow_fill       = shadow_fill + 1;
      shadow_wptr       = (wp + 1) % RING_DEPTH;
   endtask

   task automatic compute_report(output rsp_type rep);
      int unsigned     n;
      int unsigned     start;
      int unsigned     rms;
      int unsigned     peak;
      int unsigned     rate;
      int unsigned     score;
      int unsigned     mag;
      longint unsigned f;
      longint unsigned q;
      int              v;
      int              rdb;
      int              pdb;
      int              pct;
      bit              voice;
      n     = shadow_fill;
      start = (shadow_wptr + RING_DEPTH - (n % (RING_DEPTH + 1))) % RING_DEPTH;
      f     = (cfg_smoothing > Q16_ONE) ? longint'(Q16_ONE) : longint'(cfg_smoothing);
      rms   = 0;
      peak  = 0;
      rate  = 0;
      if (n > 0) rms = int'(int_sqrt(shadow_square_sum / n));
      for (int i = 0; i < n; i++) begin
         v   = shadow_ring[(start + i) % RING_DEPTH];
         mag = (v < 0) ? -v : v;
         if (mag > peak) peak = mag;
      end
      if (n >= 2) rate = int'((longint'(shadow_crossings) << 16) / n);
      rdb = level_to_db(rms);
      pdb = level_to_db(peak);
      shadow_smooth_level = int'((longint'(shadow_smooth_level) * (65536 - f)
                                  + longint'(rms) * f + 32768) >> 16);
      shadow_smooth_db = int'(round_half_away(longint'(shadow_smooth_db)
                                * longint'(65536 - f) + longint'(rdb) * longint'(f)));
      if (cfg_score_ref == 0) begin
         score = 0;
      end else begin
         q     = (longint'(rate) << 16) / cfg_score_ref;
         score = (q >= 65536) ? 0 : int'(65536 - q);
      end
      voice = (rdb >= cfg_noise_floor) && (rate < cfg_cross_thr) && (rdb > cfg_volume_thr);
      if (cfg_pct_max <= cfg_pct_min || rdb <= cfg_pct_min) pct = 0;
      else if (rdb >= cfg_pct_max) pct = int'(PERCENT_FULL);
      else pct = int'((longint'(rdb - cfg_pct_min) * 25600)
                      / (longint'(cfg_pct_max) - longint'(cfg_pct_min)));
      rep.rms_level      = 16'(rms);
      rep.rms_db         = 16'(rdb);
      rep.peak_level     = 16'(peak);
      rep.peak_db        = 16'(pdb);
      rep.smoothed_level = 16'(shadow_smooth_level);
      rep.smoothed_db    = 16'(shadow_smooth_db);
      rep.crossing_rate  = 16'(rate);
      rep.voice_score    = 17'(score);
      rep.voice_detected = voice;
      rep.volume_percent = 15'(pct);
   endtask

   // one accepted frame: update the shadow state, queue a report on evaluate
   task automatic predict_frame(req_type fr);
      int      l;
      int      r;
      int      sum;
      int      s;
      rsp_type rep;
      l = fr.left_sample;
      r = fr.right_sample;
      case (fr.op)
         OP_PUSH: begin
            // channel count 0 acts as 1, 3 as 2
            if (cfg_channels >= 2) begin
               sum = l + r;
               s = (sum >= 0) ? sum / 2 : -((1 - sum) / 2);
            end else begin
               s = l;
            end
            store_sample(s);
         end
         OP_CLEAR: begin
            shadow_wptr       = 0;
            shadow_fill       = 0;
            shadow_square_sum = 0;
            shadow_crossings  = 0;
         end
         OP_EVAL: begin
            compute_report(rep);
            queue_report(rep);
         end
         default: ;
      endcase
   endtask

   task automatic apply_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_CHANNEL_COUNT:   cfg_channels    = val[1:0];
         CSR_SMOOTHING:       cfg_smoothing   = val;
         CSR_CROSS_THRESHOLD: cfg_cross_thr   = val;
         CSR_VOLUME_THRESH:   cfg_volume_thr  = val[15:0];
         CSR_NOISE_FLOOR:     cfg_noise_floor = val[15:0];
         CSR_PERCENT_MIN:     cfg_pct_min     = val[15:0];
         CSR_PERCENT_MAX:     cfg_pct_max     = val[15:0];
         CSR_SCORE_REF:       cfg_score_ref   = val;
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- monitor

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_rep;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if (req_valid && req_ready) begin
            predict_frame(req_data);
            taken_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t unexpected result transaction, actual %0h", $realtime, rsp_data);
               error_count++;
            end else begin
               exp_rep = expected_reports.pop_front();
               check_field("rms_level", exp_rep.rms_level, rsp_data.rms_level);
               check_field("rms_db", exp_rep.rms_db, rsp_data.rms_db);
               check_field("peak_level", exp_rep.peak_level, rsp_data.peak_level);
               check_field("peak_db", exp_rep.peak_db, rsp_data.peak_db);
               check_field("smoothed_level", exp_rep.smoothed_level,
                           rsp_data.smoothed_level);
               check_field("smoothed_db", exp_rep.smoothed_db, rsp_data.smoothed_db);
               check_field("crossing_rate", exp_rep.crossing_rate, rsp_data.crossing_rate);
               check_field("voice_score", exp_rep.voice_score, rsp_data.voice_score);
               check_field("voice_detected", exp_rep.voice_detected,
                           rsp_data.voice_detected);
               check_field("volume_percent", exp_rep.volume_percent,
                           rsp_data.volume_percent);
            end
         end
      end
   end

   // ---------------------------------------------------------------- driver

   int burst_left;
   int gap_left;

   // bursts of random length, random gaps, sometimes long runs without gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (sent_count == taken_count) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_frames.size() != 0) begin
            req_data  <= pending_frames.pop_front();
            req_valid <= 1'b1;
            sent_count++;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver pattern: free running, random stalls or long stalls, by stretch
   int rx_cycle;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_cycle  = 0;
      end else begin
         rx_cycle++;
         case ((rx_cycle >> 8) % 3)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 15) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic signed [15:0] pick_sample(int mode);
      case (mode)
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(0, 127) - 64);
         2:       return ($urandom_range(0, 1) ? 16'sd32767 : -16'sd32768);
         default: return 16'($urandom_range(0, 8191) - 4096);
      endcase
   endfunction

   function automatic req_type make_frame(logic [1:0] op, logic signed [15:0] l,
                                          logic signed [15:0] r);
      req_type fr;
      fr.op           = op;
      fr.left_sample  = l;
      fr.right_sample = r;
      return fr;
   endfunction

   // mostly pushes with content of one flavor per stretch, evaluates scattered
   task automatic queue_random(int count, int clear_pct);
      int mode;
      int pick;
      mode = 0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 3);
         pick = $urandom_range(0, 99);
         if (pick < 86)
            queue_frame(make_frame(OP_PUSH, pick_sample(mode), pick_sample(mode)));
         else if (pick < 94)
            queue_frame(make_frame(OP_EVAL, 16'($urandom), 16'($urandom)));
         else if (pick < 94 + clear_pct)
            queue_frame(make_frame(OP_CLEAR, 16'($urandom), 16'($urandom)));
         else
            queue_frame(make_frame(2'd3, 16'($urandom), 16'($urandom)));
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_frames.size() != 0 || sent_count != taken_count
             || expected_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!csr_ready);
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(logic [16:0] ch, logic [16:0] sm, logic [16:0] ct,
                            logic [16:0] vt, logic [16:0] nf, logic [16:0] pmn,
                            logic [16:0] pmx, logic [16:0] sr);
      write_register(CSR_CHANNEL_COUNT, ch);
      write_register(CSR_SMOOTHING, sm);
      write_register(CSR_CROSS_THRESHOLD, ct);
      write_register(CSR_VOLUME_THRESH, vt);
      write_register(CSR_NOISE_FLOOR, nf);
      write_register(CSR_PERCENT_MIN, pmn);
      write_register(CSR_PERCENT_MAX, pmx);
      write_register(CSR_SCORE_REF, sr);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      sent_count  = 0;
      taken_count = 0;
      error_count = 0;
      shadow_wptr         = 0;
      shadow_fill         = 0;
      shadow_square_sum   = 0;
      shadow_crossings    = 0;
      shadow_smooth_level = 0;
      shadow_smooth_db    = 0;
      cfg_channels    = RST_CHANNEL_COUNT;
      cfg_smoothing   = RST_SMOOTHING;
      cfg_cross_thr   = RST_CROSS_THRESHOLD;
      cfg_volume_thr  = RST_VOLUME_THRESH;
      cfg_noise_floor = RST_NOISE_FLOOR;
      cfg_pct_min     = RST_PERCENT_MIN;
      cfg_pct_max     = RST_PERCENT_MAX;
      cfg_score_ref   = RST_SCORE_REF;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty window, unused op, extremes, sign changes, clear
      queue_frame(make_frame(OP_EVAL, 16'sd0, 16'sd0));
      queue_frame(make_frame(2'd3, -16'sd1, -16'sd1));
      queue_frame(make_frame(OP_PUSH, 16'sd0, 16'sd0));
      queue_frame(make_frame(OP_EVAL, 16'sd0, 16'sd0));
      queue_frame(make_frame(OP_PUSH, -16'sd32768, 16'sd32767));
      queue_frame(make_frame(OP_PUSH, 16'sd32767, -16'sd32768));
      queue_frame(make_frame(OP_PUSH, -16'sd1, 16'sd0));
      queue_frame(make_frame(OP_PUSH, 16'sd1, 16'sd0));
      queue_frame(make_frame(OP_EVAL, 16'sd0, 16'sd0));
      queue_frame(make_frame(OP_CLEAR, 16'sd0, 16'sd0));
      queue_frame(make_frame(OP_EVAL, 16'sd0, 16'sd0));
      queue_frame(make_frame(OP_PUSH, 16'sd32767, 16'sd0));
      queue_frame(make_frame(OP_EVAL, 16'sd0, 16'sd0));
      wait_idle();

      // two channels, widest thresholds, index past the last register ignored
      write_all(17'd2, Q16_ONE, Q16_ONE, 17'h18000, 17'h08000, 17'(-25600), 17'd0, Q16_ONE);
      write_register(4'd9, 17'h1FFFF);
      end_writes();
      queue_frame(make_frame(OP_PUSH, -16'sd32768, -16'sd32768));
      queue_frame(make_frame(OP_PUSH, -16'sd1, 16'sd0));
      queue_frame(make_frame(OP_PUSH, 16'sd32767, 16'sd32767));
      queue_frame(make_frame(OP_PUSH, 16'sd3, -16'sd6));
      queue_frame(make_frame(OP_EVAL, 16'sd0, 16'sd0));
      queue_random(20, 2);
      wait_idle();

      // channel count 0, no smoothing weight, zero reference, empty percent range
      write_all(17'd0, 17'd0, 17'd0, 17'h07FFF, 17'h07FFF, 17'd0, 17'(-100), 17'd0);
      end_writes();
      queue_random(20, 2);
      wait_idle();

      // channel count 3, oversize smoothing weight, then a run past the window
      write_all(17'd3, 17'h1FFFF, 17'd20000, 17'(-5000), 17'(-20000), 17'(-20000),
                17'(-1000), 17'd1);
      end_writes();
      for (int i = 0; i < 2052; i++) begin
         queue_frame(make_frame(OP_PUSH, pick_sample((i / 300) % 4),
                                pick_sample((i / 500) % 4)));
         if (i % 500 == 499)
            queue_frame(make_frame(OP_EVAL, 16'sd0, 16'sd0));
      end
      queue_frame(make_frame(OP_EVAL, 16'sd0, 16'sd0));
      wait_idle();

      // random settings over the full window
      for (int p = 0; p < 3; p++) begin
         write_all(17'($urandom_range(0, 3)), 17'($urandom_range(0, 70000)),
                   17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65535)),
                   17'($urandom_range(0, 65535)), 17'(-$urandom_range(0, 25600)),
                   17'(-$urandom_range(0, 25600)), 17'($urandom_range(0, 65536)));
         end_writes();
         queue_random(20, 0);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("tb_windowed_voice_activity_detector_unit: clean");
      end else begin
         $display("tb_windowed_voice_activity_detector_unit: errors");
      end
      $finish;
   end

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_windowed_voice_activity_detector_unit: errors");
      $finish;
   end

endmodule
